>>> hdl/gkt_pkg.sv
package gkt_pkg;

  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned LookupMax      = 16;

  localparam logic [2:0] OpLookup = 3'd0;
  localparam logic [2:0] OpSave   = 3'd1;
  localparam logic [2:0] OpRemove = 3'd2;
  localparam logic [2:0] OpPut    = 3'd3;
  localparam logic [2:0] OpClear  = 3'd4;

  localparam logic [1:0] StOk     = 2'd0;
  localparam logic [1:0] StReject = 2'd1;
  localparam logic [1:0] StStaged = 2'd2;
  localparam logic [1:0] StNone   = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] entry_id;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        last_key;
    logic [4:0]  max_keys;
  } gkt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] found_key_high;
    logic [63:0] found_key_low;
    logic [4:0]  key_count;
    logic        final_result;
  } gkt_out_t;

  // Datapath command from the controller.
  typedef enum logic [3:0] {
    CmdNop,
    CmdLatch,      // capture the input item, reset walk pointers
    CmdStage,      // write the key into staging
    CmdDropStage,  // empty staging
    CmdScanStep,   // read entry at read pointer, count/compare, advance
    CmdCompStep,   // compact step: move entry rd -> wr if it survives
    CmdAppendStep, // move one staged key to the table end
    CmdPut,        // append input key
    CmdClear,      // empty table
    CmdFinishCompact, // entry count <- write pointer
    CmdResetWalk   // rewind pointers
  } gkt_cmd_e;

  typedef struct packed {
    logic       scan_done;   // read pointer reached entry count
    logic       app_done;    // all staged keys appended or table full
    logic       match;       // entry at read pointer has the latched id
    logic       id_zero;
    logic       full;
    logic       stage_empty; // no keys staged and no overflow
    logic       stage_ovf;
    logic       fits;        // survivors + staged <= ENTRIES, staged id nonzero
    logic       limit_hit;   // matches reached lookup limit
    logic       any_match;
  } gkt_sts_t;

endpackage

>>> hdl/grouped_key_table_engine_unit.sv
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-----------
// in        | input     | in_valid_i/in_stall_o  | gkt_in_t
// out       | output    | out_valid_o/out_stall_i| gkt_out_t
//
// One item at a time. Put, clear and staging need no table walk; remove
// walks the table once; a save commit walks it twice and then appends
// staged keys, or rejects after one walk if they do not fit. A lookup
// counts the matches, then walks again to send them. One sequencer and
// one table read port serialise the walks. Reset clears counts only;
// table rows are undefined until written. A stalled result holds.
module grouped_key_table_engine_unit
  import gkt_pkg::*;
#(
  parameter int unsigned Entries = EntriesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gkt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output gkt_out_t out_data_o
);
  gkt_cmd_e    cmd;
  gkt_sts_t    sts;
  logic [63:0] rd_high, rd_low;
  logic [4:0]  match_cnt, count;

  gkt_controller u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts), .rd_high_i(rd_high), .rd_low_i(rd_low),
    .match_cnt_i(match_cnt), .count_i(count)
  );

  gkt_datapath #(.Entries(Entries)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .item_i(in_data_i), .sts_o(sts),
    .rd_high_o(rd_high), .rd_low_o(rd_low), .match_cnt_o(match_cnt),
    .count_o(count)
  );

endmodule

>>> hdl/gkt_datapath.sv
module gkt_datapath
  import gkt_pkg::*;
#(
  parameter int unsigned Entries = EntriesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gkt_cmd_e cmd_i,
  input  gkt_in_t  item_i,
  output gkt_sts_t sts_o,
  output logic [63:0] rd_high_o,
  output logic [63:0] rd_low_o,
  output logic [4:0]  match_cnt_o,
  output logic [4:0]  count_o
);
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);

  logic [15:0] ids_q  [Entries];
  logic [63:0] khi_q  [Entries];
  logic [63:0] klo_q  [Entries];
  logic [63:0] shi_q  [Entries];
  logic [63:0] slo_q  [Entries];

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scount_q, scount_d;
  logic [15:0]     sid_q, sid_d;
  logic            sovf_q, sovf_d;
  logic [CntW-1:0] rd_q, rd_d, wr_q, wr_d, surv_q, surv_d;
  logic [4:0]      nm_q, nm_d;
  gkt_in_t         it_q;

  logic [IdxW-1:0] rd_idx, wr_idx, sc_idx, cnt_idx;
  logic [4:0]      lim;
  logic [CntW:0]   need;
  logic [15:0]     key_id;

  assign rd_idx  = rd_q[IdxW-1:0];
  assign wr_idx  = wr_q[IdxW-1:0];
  assign sc_idx  = scount_q[IdxW-1:0];
  assign cnt_idx = count_q[IdxW-1:0];
  assign lim     = (it_q.max_keys > 5'(LookupMax)) ? 5'(LookupMax) : it_q.max_keys;
  assign need    = {1'b0, surv_q} + {1'b0, scount_q};
  // A save commit walks against the id latched at the start of the run.
  assign key_id  = (it_q.op == OpSave) ? sid_q : it_q.entry_id;

  always_comb begin
    sts_o.scan_done   = (rd_q >= count_q);
    sts_o.app_done    = (rd_q >= scount_q) || (count_q >= CntW'(Entries));
    sts_o.match       = (ids_q[rd_idx] == key_id);
    sts_o.id_zero     = (it_q.entry_id == 16'd0);
    sts_o.full        = (count_q >= CntW'(Entries));
    sts_o.stage_empty = (scount_q == '0) && !sovf_q;
    sts_o.stage_ovf   = sovf_q;
    sts_o.fits        = (need <= (CntW+1)'(Entries)) && (sid_q != 16'd0);
    sts_o.limit_hit   = (nm_q >= lim);
    sts_o.any_match   = (nm_q != 5'd0);
  end

  assign rd_high_o   = khi_q[rd_idx];
  assign rd_low_o    = klo_q[rd_idx];
  assign match_cnt_o = nm_q;
  assign count_o     = 5'(count_q);

  always_comb begin
    count_d  = count_q;
    scount_d = scount_q;
    sid_d    = sid_q;
    sovf_d   = sovf_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    surv_d   = surv_q;
    nm_d     = nm_q;
    case (cmd_i)
      CmdLatch, CmdResetWalk: begin
        rd_d = '0; wr_d = '0; surv_d = '0; nm_d = '0;
      end
      CmdStage: begin
        if (scount_q == '0 && !sovf_q) sid_d = it_q.entry_id;
        if (scount_q < CntW'(Entries)) scount_d = scount_q + 1'b1;
        else sovf_d = 1'b1;
      end
      CmdDropStage: begin
        scount_d = '0; sid_d = '0; sovf_d = 1'b0;
      end
      CmdScanStep: begin
        rd_d = rd_q + 1'b1;
        if (ids_q[rd_idx] != key_id) surv_d = surv_q + 1'b1;
        else nm_d = nm_q + 5'd1;
      end
      CmdCompStep: begin
        rd_d = rd_q + 1'b1;
        if (ids_q[rd_idx] != key_id) wr_d = wr_q + 1'b1;
      end
      CmdFinishCompact: begin
        count_d = wr_q;
        rd_d    = '0;
      end
      CmdAppendStep: begin
        rd_d = rd_q + 1'b1;
        count_d = count_q + 1'b1;
      end
      CmdPut: begin
        count_d = count_q + 1'b1;
        scount_d = '0; sid_d = '0; sovf_d = 1'b0;
      end
      CmdClear: begin
        count_d = '0;
        scount_d = '0; sid_d = '0; sovf_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; scount_q <= '0; sid_q <= '0; sovf_q <= 1'b0;
      rd_q <= '0; wr_q <= '0; surv_q <= '0; nm_q <= '0;
    end else begin
      count_q <= count_d; scount_q <= scount_d; sid_q <= sid_d; sovf_q <= sovf_d;
      rd_q <= rd_d; wr_q <= wr_d; surv_q <= surv_d; nm_q <= nm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CmdLatch) it_q <= item_i;
    case (cmd_i)
      CmdStage: begin
        if (scount_q < CntW'(Entries)) begin
          shi_q[sc_idx] <= it_q.key_high;
          slo_q[sc_idx] <= it_q.key_low;
        end
      end
      CmdCompStep: begin
        if (ids_q[rd_idx] != key_id) begin
          ids_q[wr_idx] <= ids_q[rd_idx];
          khi_q[wr_idx] <= khi_q[rd_idx];
          klo_q[wr_idx] <= klo_q[rd_idx];
        end
      end
      CmdAppendStep: begin
        ids_q[cnt_idx] <= sid_q;
        khi_q[cnt_idx] <= shi_q[rd_idx];
        klo_q[cnt_idx] <= slo_q[rd_idx];
      end
      CmdPut: begin
        ids_q[cnt_idx] <= it_q.entry_id;
        khi_q[cnt_idx] <= it_q.key_high;
        klo_q[cnt_idx] <= it_q.key_low;
      end
      default: ;
    endcase
  end

endmodule

>>> hdl/gkt_controller.sv
module gkt_controller
  import gkt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  gkt_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output gkt_out_t    out_data_o,
  output gkt_cmd_e    cmd_o,
  input  gkt_sts_t    sts_i,
  input  logic [63:0] rd_high_i,
  input  logic [63:0] rd_low_i,
  input  logic [4:0]  match_cnt_i,
  input  logic [4:0]  count_i
);
  typedef enum logic [3:0] {
    SIdle, SDispatch, SLkCount, SLkRewind, SLkEmit, SLkWait,
    SSvScan, SSvComp, SSvFinish, SSvAppend, SRmComp, SRmFinish,
    SRespond, SWait
  } state_e;

  state_e   state_q;
  gkt_in_t  it_q;
  logic [4:0] total_q, sent_q;
  logic [1:0] st_q;
  logic     mode_q; // 1: save commit rejected, drop staged keys instead of appending
  gkt_out_t out_q;
  logic     ov_q;

  assign in_stall_o  = (state_q != SIdle);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  logic lim_hit;
  logic [4:0] lim;
  assign lim = (it_q.max_keys > 5'(LookupMax)) ? 5'(LookupMax) : it_q.max_keys;
  assign lim_hit = (sent_q >= total_q);

  always_comb begin
    cmd_o = CmdNop;
    case (state_q)
      SIdle: if (in_valid_i) begin
        cmd_o = CmdLatch;
      end
      SDispatch: begin
        case (it_q.op)
          OpSave:  cmd_o = CmdStage;
          OpPut:   cmd_o = sts_i.full ? CmdDropStage : CmdPut;
          OpClear: cmd_o = CmdClear;
          default: cmd_o = CmdDropStage;
        endcase
      end
      SLkCount: if (!sts_i.scan_done && !sts_i.limit_hit) cmd_o = CmdScanStep;
      SLkRewind: cmd_o = CmdResetWalk;
      SLkEmit: if (!sts_i.scan_done && !sts_i.match) cmd_o = CmdScanStep;
      SLkWait: if (!out_stall_i) cmd_o = CmdScanStep;
      SSvScan: begin
        if (!sts_i.scan_done) cmd_o = CmdScanStep;
        else if (sts_i.fits && !sts_i.stage_ovf) cmd_o = CmdResetWalk;
      end
      SSvComp, SRmComp: if (!sts_i.scan_done) cmd_o = CmdCompStep;
      SSvFinish, SRmFinish: cmd_o = CmdFinishCompact;
      SSvAppend: cmd_o = (sts_i.app_done || mode_q) ? CmdDropStage : CmdAppendStep;
      default: ;
    endcase
  end

  // Lookup emit walks with scan steps: they only advance the read pointer
  // and the counters, so the table is never written during a lookup.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; ov_q <= 1'b0; total_q <= '0; sent_q <= '0;
      st_q <= StOk; mode_q <= 1'b0; it_q <= '0; out_q <= '0;
    end else begin
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      case (state_q)
        SIdle: if (in_valid_i) begin
          it_q <= in_data_i;
          state_q <= SDispatch;
        end
        SDispatch: begin
          case (it_q.op)
            OpLookup: state_q <= SLkCount;
            OpSave: begin
              if (!it_q.last_key) begin st_q <= StStaged; state_q <= SRespond; end
              else state_q <= SSvScan;
            end
            OpRemove: begin
              if (it_q.entry_id == 16'd0) begin st_q <= StReject; state_q <= SRespond; end
              else state_q <= SRmComp;
            end
            OpPut: begin
              st_q <= sts_i.full ? StReject : StOk; state_q <= SRespond;
            end
            OpClear: begin st_q <= StOk; state_q <= SRespond; end
            default: begin st_q <= StReject; state_q <= SRespond; end
          endcase
        end
        SLkCount: begin
          total_q <= lim;
          if (sts_i.scan_done || sts_i.limit_hit) begin
            total_q <= match_cnt_i;
            sent_q <= '0;
            state_q <= (match_cnt_i == 5'd0) ? SRespond : SLkRewind;
            st_q <= StNone;
          end
        end
        SLkRewind: state_q <= SLkEmit;
        SLkEmit: if (sts_i.match && !ov_q) begin
          out_q.status         <= StOk;
          out_q.found_key_high <= rd_high_i;
          out_q.found_key_low  <= rd_low_i;
          out_q.key_count      <= total_q;
          out_q.final_result   <= (sent_q + 5'd1 == total_q);
          ov_q   <= 1'b1;
          sent_q <= sent_q + 5'd1;
          state_q <= SLkWait;
        end
        SLkWait: if (!out_stall_i) begin
          state_q <= lim_hit ? SIdle : SLkEmit;
        end
        SSvScan: if (sts_i.scan_done) begin
          if (sts_i.fits && !sts_i.stage_ovf) state_q <= SSvComp;
          else begin st_q <= StReject; state_q <= SSvAppend; mode_q <= 1'b1; end
        end
        SSvComp: if (sts_i.scan_done) state_q <= SSvFinish;
        SSvFinish: begin st_q <= StOk; mode_q <= 1'b0; state_q <= SSvAppend; end
        SSvAppend: if (sts_i.app_done || mode_q) state_q <= SRespond;
        SRmComp: if (sts_i.scan_done) state_q <= SRmFinish;
        SRmFinish: begin st_q <= StOk; state_q <= SRespond; end
        SRespond: if (!ov_q || !out_stall_i) begin
          out_q.status         <= st_q;
          out_q.found_key_high <= '0;
          out_q.found_key_low  <= '0;
          out_q.key_count      <= (st_q == StNone) ? 5'd0 : count_i;
          out_q.final_result   <= 1'b1;
          ov_q    <= 1'b1;
          mode_q  <= 1'b0;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
